// File: rtl/asft_pkg.sv
// shared constants for the adb stream flow tracker
// no dependencies
package asft_pkg;
	localparam int PendDepth = 16;
	localparam int StrmDepth = 31;
	localparam int SnipMax = 32;
	localparam int PW = $clog2(PendDepth + 1);
	localparam int SW = $clog2(StrmDepth + 1);
	localparam logic [31:0] CMD_OPEN = 32'h4E45504F;
	localparam logic [31:0] CMD_OKAY = 32'h59414B4F;
	localparam logic [31:0] CMD_CLSE = 32'h45534C43;
	localparam logic [31:0] CMD_WRTE = 32'h45545257;
	localparam logic [39:0] SYNC_PREFIX = 40'h3A636E7973;
	localparam logic [1:0] PH_INSTANT = 2'd0;
	localparam logic [1:0] PH_BEGIN = 2'd1;
	localparam logic [1:0] PH_STEP = 2'd2;
	localparam logic [1:0] PH_END = 2'd3;
endpackage

// File: rtl/asft_if.sv
// stream channel interfaces for packet headers and log records
// no dependencies
interface asft_in_if;
	logic valid, ready;
	logic [31:0] opcode, first_id, second_id;
	logic [20:0] payload_length;
	logic toward_guest, payload_present;
	logic [39:0] leading_bytes;
	modport source(output valid, opcode, first_id, second_id, payload_length,
		toward_guest, payload_present, leading_bytes, input ready);
	modport sink(input valid, opcode, first_id, second_id, payload_length,
		toward_guest, payload_present, leading_bytes, output ready);
endinterface

interface asft_out_if;
	logic valid, ready;
	logic [63:0] flow_id;
	logic [1:0] phase;
	logic direction;
	logic [31:0] command_echo;
	logic sync_stream;
	logic [5:0] snippet_length;
	modport source(output valid, flow_id, phase, direction, command_echo, sync_stream,
		snippet_length, input ready);
	modport sink(input valid, flow_id, phase, direction, command_echo, sync_stream,
		snippet_length, output ready);
endinterface

// File: rtl/adb_stream_flow_tracker.sv
// adb stream flow tracker top level, two shared compare units under a sequencer
// depends on asft_pkg and the channel interfaces in asft_if
//
// usage: packet headers enter on in_ch, one log record per header leaves on
// out_ch. capture_we/capture_data write the snippet capture enable.
// each transaction is handled by two key compare units that walk the tables
// one entry per cycle; entries are removed by shifting, one entry per cycle.
// one header is in work at a time; in_ch.ready is low until the record has
// been handed to the output register. a stalled receiver holds the record and
// blocks the next header once the next one finishes.
// reset clears both table counts and the capture enable; the table contents
// need no clearing since entries past a count are never read.
module adb_stream_flow_tracker
	import asft_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic capture_we,
	input logic capture_data,
	asft_in_if.sink in_ch,
	asft_out_if.source out_ch
);
	localparam logic [3:0] S_IDLE = 4'd0, S_PFIND = 4'd1, S_PSHIFT = 4'd2,
		S_PAPP = 4'd3, S_SFIND = 4'd4, S_SSHIFT = 4'd5, S_SAPP = 4'd6,
		S_LOOK = 4'd7, S_OUT = 4'd8, S_EVICT = 4'd9;

	logic [3:0] st_q;
	logic cap_q;
	logic [32:0] pkey_q [PendDepth];
	logic psync_q [PendDepth];
	logic [PW-1:0] pcnt_q;
	logic [63:0] sflow_q [StrmDepth];
	logic ssync_q [StrmDepth];
	logic [SW-1:0] scnt_q;
	logic [31:0] op_q, a0_q, a1_q;
	logic [20:0] len_q;
	logic tg_q, pres_q;
	logic [39:0] lead_q;
	logic [6:0] idx_q;
	logic [1:0] pass_q;   // clse erases up to two pending keys
	logic hit_sync_q, sync_q;
	logic [32:0] key_q;
	logic [63:0] look;
	logic [32:0] open_key, okay_key;
	logic pk_match, sf_match;
	logic [5:0] snip;

	assign look = tg_q ? {a0_q, a1_q} : {a1_q, a0_q};
	assign open_key = {tg_q, a0_q};
	assign okay_key = {~tg_q, a1_q};
	// shared compare units
	assign pk_match = pkey_q[idx_q[$clog2(PendDepth)-1:0]] == key_q;
	assign sf_match = sflow_q[idx_q[$clog2(StrmDepth)-1:0]] == look;

	always_comb begin
		if (pres_q && op_q == CMD_WRTE && sync_q && len_q >= 21'd4)
			snip = 6'd4;
		else if (pres_q && cap_q)
			snip = (len_q < 21'(SnipMax)) ? len_q[5:0] : 6'(SnipMax);
		else
			snip = 6'd0;
	end

	assign in_ch.ready = (st_q == S_IDLE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			pcnt_q <= '0;
			scnt_q <= '0;
			cap_q <= 1'b0;
			out_ch.valid <= 1'b0;
		end else begin
			if (capture_we) cap_q <= capture_data;
			// output register: load a finished record, clear on handoff
			if (st_q == S_OUT && (!out_ch.valid || out_ch.ready)) out_ch.valid <= 1'b1;
			else if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
			unique case (st_q)
				S_IDLE: if (in_ch.valid) begin
					op_q <= in_ch.opcode;
					a0_q <= in_ch.first_id;
					a1_q <= in_ch.second_id;
					len_q <= in_ch.payload_length;
					tg_q <= in_ch.toward_guest;
					pres_q <= in_ch.payload_present;
					lead_q <= in_ch.leading_bytes;
					idx_q <= '0;
					pass_q <= '0;
					if (in_ch.opcode == CMD_OPEN && in_ch.payload_present) begin
						key_q <= {in_ch.toward_guest, in_ch.first_id};
						st_q <= S_PFIND;
					end else if (in_ch.opcode == CMD_OKAY) begin
						key_q <= {~in_ch.toward_guest, in_ch.second_id};
						st_q <= S_PFIND;
					end else if (in_ch.opcode == CMD_CLSE) begin
						st_q <= S_SFIND;
					end else begin
						st_q <= S_LOOK;
					end
				end
				// search pending table for key_q
				S_PFIND: begin
					if (7'(pcnt_q) == idx_q) begin
						// miss
						if (op_q == CMD_OPEN) begin
							idx_q <= '0;
							st_q <= (7'(pcnt_q) >= 7'(PendDepth)) ? S_PSHIFT : S_PAPP;
						end else if (op_q == CMD_CLSE && pass_q == 2'd0) begin
							pass_q <= 2'd1;
							key_q <= okay_key;
							idx_q <= '0;
						end else begin
							idx_q <= '0;
							st_q <= S_LOOK;
						end
					end else if (pk_match) begin
						hit_sync_q <= psync_q[idx_q[$clog2(PendDepth)-1:0]];
						st_q <= S_PSHIFT;
					end else begin
						idx_q <= idx_q + 7'd1;
					end
				end
				// close the gap at idx_q
				S_PSHIFT: begin
					if (idx_q + 7'd1 >= 7'(pcnt_q)) begin
						pcnt_q <= pcnt_q - PW'(1);
						idx_q <= '0;
						if (op_q == CMD_OPEN) st_q <= S_PAPP;
						else if (op_q == CMD_OKAY)
							st_q <= (7'(scnt_q) >= 7'(StrmDepth)) ? S_EVICT : S_SAPP;
						else if (pass_q == 2'd0) begin
							pass_q <= 2'd1;
							key_q <= okay_key;
							st_q <= S_PFIND;
						end else st_q <= S_LOOK;
					end else begin
						pkey_q[idx_q[$clog2(PendDepth)-1:0]] <=
							pkey_q[idx_q[$clog2(PendDepth)-1:0] + 1'b1];
						psync_q[idx_q[$clog2(PendDepth)-1:0]] <=
							psync_q[idx_q[$clog2(PendDepth)-1:0] + 1'b1];
						idx_q <= idx_q + 7'd1;
					end
				end
				S_PAPP: begin
					pkey_q[pcnt_q[$clog2(PendDepth)-1:0]] <= open_key;
					psync_q[pcnt_q[$clog2(PendDepth)-1:0]] <=
						(len_q >= 21'd5) && (lead_q == SYNC_PREFIX);
					pcnt_q <= pcnt_q + PW'(1);
					st_q <= S_LOOK;
				end
				S_EVICT: st_q <= S_SSHIFT;
				// search stream list for the clse flow
				S_SFIND: begin
					if (7'(scnt_q) == idx_q) begin
						idx_q <= '0;
						key_q <= open_key;
						st_q <= S_PFIND;
					end else if (sf_match) st_q <= S_SSHIFT;
					else idx_q <= idx_q + 7'd1;
				end
				S_SSHIFT: begin
					if (idx_q + 7'd1 >= 7'(scnt_q)) begin
						scnt_q <= scnt_q - SW'(1);
						idx_q <= '0;
						if (op_q == CMD_OKAY) st_q <= S_SAPP;
						else begin
							key_q <= open_key;
							st_q <= S_PFIND;
						end
					end else begin
						sflow_q[idx_q[$clog2(StrmDepth)-1:0]] <=
							sflow_q[idx_q[$clog2(StrmDepth)-1:0] + 1'b1];
						ssync_q[idx_q[$clog2(StrmDepth)-1:0]] <=
							ssync_q[idx_q[$clog2(StrmDepth)-1:0] + 1'b1];
						idx_q <= idx_q + 7'd1;
					end
				end
				S_SAPP: begin
					sflow_q[scnt_q[$clog2(StrmDepth)-1:0]] <= look;
					ssync_q[scnt_q[$clog2(StrmDepth)-1:0]] <= hit_sync_q;
					scnt_q <= scnt_q + SW'(1);
					idx_q <= '0;
					st_q <= S_LOOK;
				end
				// lookup after update
				S_LOOK: begin
					if (7'(scnt_q) == idx_q) begin
						sync_q <= 1'b0;
						st_q <= S_OUT;
					end else if (sf_match) begin
						sync_q <= ssync_q[idx_q[$clog2(StrmDepth)-1:0]];
						st_q <= S_OUT;
					end else idx_q <= idx_q + 7'd1;
				end
				S_OUT: if (!out_ch.valid || out_ch.ready) begin
					out_ch.flow_id <= {a0_q, a1_q};
					out_ch.phase <= (op_q == CMD_OPEN) ? PH_BEGIN :
						(op_q == CMD_CLSE) ? PH_END :
						(op_q == CMD_WRTE || op_q == CMD_OKAY) ? PH_STEP : PH_INSTANT;
					out_ch.direction <= tg_q;
					out_ch.command_echo <= op_q;
					out_ch.sync_stream <= sync_q;
					out_ch.snippet_length <= snip;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: rtl/asft_checker.sv
// port level checks for the adb stream flow tracker
// depends on the top level ports; bound below
module asft_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [31:0] out_cmd
);
	// a stalled record holds its command
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_cmd)) else $error("record lost");
	// an accepted header drops ready
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("ready after accept");
	// no record appears without work in flight
	a_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready)) else $error("spurious record");
endmodule

bind adb_stream_flow_tracker asft_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_cmd(out_ch.command_echo));
